// ===== src/lwh_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the LFSR word function of the word histogram block.
package lwh_pkg;

  localparam int WORD_W    = 24;
  localparam int COUNT_W   = 25;
  localparam int BIN_OUT_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [WORD_W-1:0]  SEED_RESET = WORD_W'(1);

  // Feedback taps besides bit 0
  localparam int TAP_A = 19;
  localparam int TAP_B = 20;
  localparam int TAP_C = 22;
  localparam int TAP_D = 23;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [WORD_W-1:0] state;
    logic [WORD_W-1:0] word;
  } lfsr_result_t;

  // 24 shifts of the LFSR; flattens into a fixed XOR network.
  function automatic lfsr_result_t lfsr_run(input logic [WORD_W-1:0] start);
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] w;
    logic              fb;
    lfsr_result_t      res;
    r = start;
    w = '0;
    for (int i = 0; i < WORD_W; i++) begin
      fb = r[0] ^ r[TAP_A] ^ r[TAP_B] ^ r[TAP_C] ^ r[TAP_D];
      w  = {w[WORD_W-2:0], r[0]};
      r  = {fb, r[WORD_W-1:1]};
    end
    res.state = r;
    res.word  = w;
    return res;
  endfunction

endpackage

// ===== src/lwh_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lwh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lwh_front.sv =====
`timescale 1ns / 1ps
// Front end: seed register, LFSR state, word generation and bin classification.
module lwh_front #(
  parameter int BINS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        seed_we,
  input  logic [lwh_pkg::WORD_W-1:0]  seed_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        restart,
  input  lwh_pkg::q_status_t          q_status,
  output logic                        push,
  output logic                        push_restart,
  output logic [$clog2(BINS)-1:0]     push_bin,
  output logic [lwh_pkg::WORD_W-1:0]  push_word
);
  import lwh_pkg::*;

  localparam int BW   = $clog2(BINS);
  localparam int SPAN = (1 << WORD_W) / BINS;

  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] shift_reg;
  logic [WORD_W-1:0] start;
  lfsr_result_t      gen;
  logic [BINS-1:0]   above;
  logic [BW-1:0]     bin_idx;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  assign start = restart ? seed : shift_reg;
  assign gen   = lfsr_run(start);

  // Threshold compares; the last bin also takes any remainder above the top span.
  assign above[0] = 1'b1;
  for (genvar k = 1; k < BINS; k++) begin : g_thr
    assign above[k] = ({1'b0, gen.word} >= (WORD_W + 1)'(k * SPAN));
  end

  always_comb begin
    bin_idx = '0;
    for (int k = 1; k < BINS; k++) begin
      if (above[k]) begin
        bin_idx = BW'(k);
      end
    end
  end

  assign push_restart = restart;
  assign push_bin     = bin_idx;
  assign push_word    = gen.word;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SEED_RESET;
      shift_reg <= SEED_RESET;
    end else begin
      if (seed_we) begin
        seed <= seed_wdata;
      end
      if (push) begin
        shift_reg <= gen.state;
      end
    end
  end

endmodule

// ===== src/lwh_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO that decouples the front end from the histogram back end.
module lwh_queue #(
  parameter int DATA_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [DATA_W-1:0]  push_data,
  input  logic               pop,
  output logic [DATA_W-1:0]  head,
  output lwh_pkg::q_status_t status
);
  import lwh_pkg::*;

  logic [DATA_W-1:0]   mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/lwh_back.sv =====
`timescale 1ns / 1ps
// Back end: histogram counters in RAM with valid bits, increment and output register.
module lwh_back #(
  parameter int BINS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lwh_pkg::q_status_t             q_status,
  input  logic                           head_restart,
  input  logic [$clog2(BINS)-1:0]        head_bin,
  input  logic [lwh_pkg::WORD_W-1:0]     head_word,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lwh_pkg::WORD_W-1:0]     word,
  output logic [lwh_pkg::BIN_OUT_W-1:0]  bin,
  output logic [lwh_pkg::COUNT_W-1:0]    bin_count
);
  import lwh_pkg::*;

  localparam int BW = $clog2(BINS);

  logic               s1_valid;
  logic               s1_restart;
  logic [BW-1:0]      s1_bin;
  logic [WORD_W-1:0]  s1_word;
  logic               s1_fire;
  logic [BINS-1:0]    hist_valid;
  logic [BINS-1:0]    hist_valid_next;
  logic               fwd_valid;
  logic [BW-1:0]      fwd_bin;
  logic [COUNT_W-1:0] fwd_count;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] old_count;
  logic [COUNT_W-1:0] new_count;

  assign s1_fire = s1_valid && (!out_valid || !out_stall);
  assign pop     = !q_status.empty && (!s1_valid || s1_fire);

  lwh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_bin),
    .wdata (new_count),
    .re    (pop),
    .raddr (head_bin),
    .rdata (rd_count)
  );

  // The read was issued at the edge of the last write; forward that write.
  always_comb begin
    if (s1_restart) begin
      old_count = '0;
    end else if (fwd_valid && (fwd_bin == s1_bin)) begin
      old_count = fwd_count;
    end else if (hist_valid[s1_bin]) begin
      old_count = rd_count;
    end else begin
      old_count = '0;
    end
    new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);
  end

  always_comb begin
    hist_valid_next = s1_restart ? '0 : hist_valid;
    hist_valid_next[s1_bin] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fwd_valid  <= 1'b0;
      hist_valid <= '0;
    end else begin
      if (pop) begin
        s1_valid  <= 1'b1;
        fwd_valid <= s1_fire;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid  <= 1'b1;
        hist_valid <= hist_valid_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_restart <= head_restart;
      s1_bin     <= head_bin;
      s1_word    <= head_word;
      fwd_bin    <= s1_bin;
      fwd_count  <= new_count;
    end
    if (s1_fire) begin
      word      <= s1_word;
      bin       <= BIN_OUT_W'(s1_bin);
      bin_count <= new_count;
    end
  end

endmodule

// ===== src/lfsr24_word_histogram_top.sv =====
`timescale 1ns / 1ps
// Top level of the 24-bit LFSR word generator with a saturating bin histogram.
//
// Each accepted input transaction produces one result transaction: the next
// 24-bit word of a right-shifting Fibonacci LFSR (taps 0, 19, 20, 22, 23; the
// first bit out is the MSB), its bin, and that bin's histogram count after a
// saturating increment. With restart high, the LFSR reloads from the seed
// register and every bin is cleared before the word is made. The seed is
// written through seed_we/seed_wdata and takes effect on the next restart;
// write it only while the block is idle. Throughput is one transaction per
// clock while no stall holds the flow: the 24 shifts form one XOR network in
// the front end. A 4-entry queue separates the front end from the back end,
// whose histogram RAM has a registered read; an accepted transaction passes
// through the queue, the back end's stage register and its output register.
// Input stall rises only when the queue is full. Histogram clearing uses one
// valid bit per bin, so reset and restart clear all bins at once with no clearing pass.
module lfsr24_word_histogram_top #(
  parameter int BINS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           seed_we,
  input  logic [lwh_pkg::WORD_W-1:0]     seed_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lwh_pkg::WORD_W-1:0]     word,
  output logic [lwh_pkg::BIN_OUT_W-1:0]  bin,
  output logic [lwh_pkg::COUNT_W-1:0]    bin_count
);
  import lwh_pkg::*;

  localparam int BW     = $clog2(BINS);
  localparam int ITEM_W = 1 + BW + WORD_W;

  q_status_t         q_status;
  logic              push;
  logic              push_restart;
  logic [BW-1:0]     push_bin;
  logic [WORD_W-1:0] push_word;
  logic              pop;
  logic [ITEM_W-1:0] head;

  // Advance the LFSR and classify the word as the transaction enters.
  lwh_front #(
    .BINS (BINS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .seed_we      (seed_we),
    .seed_wdata   (seed_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .q_status     (q_status),
    .push         (push),
    .push_restart (push_restart),
    .push_bin     (push_bin),
    .push_word    (push_word)
  );

  // Hold classified words until the histogram side can take them.
  lwh_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_restart, push_bin, push_word}),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Update the bin counter and register the result.
  lwh_back #(
    .BINS (BINS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head_restart (head[ITEM_W-1]),
    .head_bin     (head[WORD_W +: BW]),
    .head_word    (head[WORD_W-1:0]),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .word         (word),
    .bin          (bin),
    .bin_count    (bin_count)
  );

endmodule

// ===== src/lwh_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the word histogram block and their bind.
module lwh_checker #(
  parameter int BINS = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lwh_pkg::WORD_W-1:0]     word,
  input logic [lwh_pkg::BIN_OUT_W-1:0]  bin,
  input logic [lwh_pkg::COUNT_W-1:0]    bin_count
);
  import lwh_pkg::*;

  // Drop any result during and right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word) && $stable(bin)
      && $stable(bin_count))
    else $error("stalled result changed");

  // A count is reported after its increment, so it is never zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_count != '0)
    else $error("zero bin count reported");

  // With sixteen bins the bin is the word's top nibble.
  a_bin_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && (BINS == 16) |-> bin == word[WORD_W-1 -: BIN_OUT_W])
    else $error("bin does not match word");

endmodule

bind lfsr24_word_histogram_top lwh_checker #(
  .BINS (BINS)
) u_lwh_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .word      (word),
  .bin       (bin),
  .bin_count (bin_count)
);
